[sv/stq_pkg.sv]
`timescale 1ns / 1ps
package stq_pkg;
  localparam int QueueDepth = 64;
  localparam int IdxW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int TidW = 8;
  localparam int MaxResults = 64;
  localparam int ResCntW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    CMD_PAUSE   = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_EXPIRE  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [TidW-1:0] thread;
    logic [7:0]      saved;
    logic [63:0]     wake;
    logic [63:0]     start;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic pause_op;  // insert at found position (all compares done in one step)
    logic restart_op;
    logic pop;       // remove head
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic found;
    logic head_due;
    logic empty;
  } dp_stat_t;
endpackage

[sv/sorted_timer_wait_queue.sv]
`timescale 1ns / 1ps
// channel | dir | fields
// in_*    | in  | tdata: command, thread_id, thread_state, duration_ms, now_ms
// out_*   | out | tdata: status, woke, woken_thread, restored_state, elapsed_ms,
//         |     |        next_wait_ms; tlast: last
// Pause, restart and non-popping expire: the item is registered, then compared
// across all slots and shifted. Expire pops one entry per S_EXEC/S_OUT pass;
// the result register is held until its transfer; the next pop waits for it.
// rst_n synchronous: empties the queue, no clearing pass.
module sorted_timer_wait_queue import stq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] command, [9:2] thread_id, [17:10] thread_state,
  // [49:18] duration_ms, [113:50] now_ms, [119:114] zero
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [2] woke, [10:3] woken_thread, [18:11] restored_state,
  // [82:19] elapsed_ms, [146:83] next_wait_ms, [151:147] zero
  output logic [151:0] out_tdata,
  output logic         out_tlast
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  entry_t   head;
  logic [63:0] now_q;
  logic [1:0]  o_status;
  logic        o_woke;
  logic [7:0]  o_thr, o_st;
  logic [63:0] o_elapsed, o_next;

  stq_datapath u_dp (
    .clk, .rst_n, .cmd,
    .in_thread(in_tdata[9:2]), .in_state(in_tdata[17:10]),
    .in_dur(in_tdata[49:18]), .in_now(in_tdata[113:50]),
    .stat, .head, .now_q
  );

  stq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_tvalid && in_tready), .in_cmd(in_tdata[1:0]),
    .stat, .head, .now_q,
    .in_ready(in_tready), .cmd,
    .o_valid(out_tvalid), .o_ready(out_tready),
    .o_status, .o_woke, .o_thr, .o_st, .o_elapsed, .o_next, .o_last(out_tlast)
  );

  assign out_tdata = {5'd0, o_next, o_elapsed, o_st, o_thr, o_woke, o_status};
endmodule

[sv/stq_datapath.sv]
`timescale 1ns / 1ps
module stq_datapath import stq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  dp_cmd_t         cmd,
  input  logic [7:0]      in_thread,
  input  logic [7:0]      in_state,
  input  logic [31:0]     in_dur,
  input  logic [63:0]     in_now,
  output dp_stat_t        stat,
  output entry_t          head,
  output logic [63:0]     now_q
);
  // Shift-register queue: each slot compares against the item and picks
  // its next value from itself, a neighbor or the incoming entry.
  entry_t          q_r [QueueDepth];
  logic [CntW-1:0] count_r;
  logic [7:0]      thr_r, st_r;
  logic [63:0]     now_r, tgt_r;

  logic [QueueDepth-1:0] gt, hit, valid, before_hit;

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      valid[i] = CntW'(i) < count_r;
      gt[i]    = valid[i] && (q_r[i].wake > tgt_r);
      hit[i]   = valid[i] && (q_r[i].thread == thr_r);
    end
    before_hit[0] = 1'b0;
    for (int i = 1; i < QueueDepth; i++) before_hit[i] = before_hit[i-1] | hit[i-1];
  end

  // insertion slot: first gt, else count
  logic [QueueDepth-1:0] ins_ge;
  always_comb begin
    ins_ge[0] = gt[0] || (count_r == '0);
    for (int i = 1; i < QueueDepth; i++)
      ins_ge[i] = gt[i] || (CntW'(i) == count_r) || ins_ge[i-1];
  end

  entry_t first_hit;
  always_comb begin
    first_hit = q_r[0];
    for (int i = QueueDepth - 1; i >= 0; i--)
      if (hit[i]) first_hit = q_r[i];
  end

  entry_t new_e, hit_head;
  assign new_e    = '{thread: thr_r, saved: st_r, wake: tgt_r, start: now_r};
  assign hit_head = '{thread: first_hit.thread, saved: first_hit.saved,
                      wake: 64'd0, start: first_hit.start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.pause_op) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.pop) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      thr_r <= in_thread;
      st_r  <= in_state;
      now_r <= in_now;
      tgt_r <= in_now + {32'd0, in_dur};
    end
    if (cmd.pause_op) begin
      if (ins_ge[0]) q_r[0] <= new_e;
      for (int i = 1; i < QueueDepth; i++) begin
        if (ins_ge[i-1]) begin
          q_r[i] <= q_r[i-1];
        end else if (ins_ge[i]) begin
          q_r[i] <= new_e;
        end
      end
    end else if (cmd.restart_op) begin
      q_r[0] <= hit_head;
      for (int i = 1; i < QueueDepth; i++)
        if (!before_hit[i]) q_r[i] <= q_r[i-1];
    end else if (cmd.pop) begin
      for (int i = 0; i < QueueDepth - 1; i++) q_r[i] <= q_r[i+1];
    end
  end

  assign stat.full     = count_r == CntW'(QueueDepth);
  assign stat.found    = |hit;
  assign stat.empty    = count_r == '0;
  assign stat.head_due = valid[0] && (q_r[0].wake <= now_r);
  assign head  = q_r[0];
  assign now_q = now_r;
endmodule

[sv/stq_ctrl.sv]
`timescale 1ns / 1ps
module stq_ctrl import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [1:0]  in_cmd,
  input  dp_stat_t    stat,
  input  entry_t      head,
  input  logic [63:0] now_q,
  output logic        in_ready,
  output dp_cmd_t     cmd,
  output logic        o_valid,
  input  logic        o_ready,
  output logic [1:0]  o_status,
  output logic        o_woke,
  output logic [7:0]  o_thr,
  output logic [7:0]  o_st,
  output logic [63:0] o_elapsed,
  output logic [63:0] o_next,
  output logic        o_last
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;
  state_t state_r;
  cmd_t   op_r;
  logic [ResCntW-1:0] npop_r;

  logic out_free;
  assign out_free = !o_valid || o_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;

  // pop only when the output register can take the popped entry
  logic can_pop, exp_step, more_due, valid_set;
  logic [63:0] next_wait;
  status_t done_status;
  assign exp_step = (state_r == S_EXEC) && (op_r == CMD_EXPIRE) && out_free;
  assign more_due = stat.head_due && npop_r != ResCntW'(MaxResults);
  assign can_pop  = exp_step && more_due;
  assign next_wait = (!stat.empty && !stat.head_due) ? head.wake - now_q : '0;
  // popped result is raised from S_OUT, in the cycle after the pop, once the queue has settled
  assign valid_set = ((state_r == S_EXEC) && out_free && !can_pop) || (state_r == S_OUT);

  always_comb begin
    done_status = ST_OK;
    if (op_r == CMD_PAUSE && stat.full) begin
      done_status = ST_FULL;
    end else if (op_r == CMD_RESTART && !stat.found) begin
      done_status = ST_NOTFOUND;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load       = in_fire;
    cmd.pause_op   = (state_r == S_EXEC) && op_r == CMD_PAUSE && !stat.full && out_free;
    cmd.restart_op = (state_r == S_EXEC) && op_r == CMD_RESTART && stat.found && out_free;
    cmd.pop        = can_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      o_valid <= 1'b0;
      op_r    <= CMD_NONE;
      npop_r  <= '0;
    end else begin
      o_valid <= valid_set || (o_valid && !o_ready);
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          op_r    <= cmd_t'(in_cmd);
          npop_r  <= '0;
          state_r <= S_EXEC;
        end
        S_EXEC: if (out_free) begin
          if (can_pop) begin
            o_status  <= ST_OK;
            o_woke    <= 1'b1;
            o_thr     <= head.thread;
            o_st      <= head.saved;
            o_elapsed <= now_q - head.start;
            o_next    <= '0;
            o_last    <= 1'b0;
            npop_r    <= npop_r + 1'b1;
            state_r   <= S_OUT;
          end else begin
            o_status  <= done_status;
            o_woke    <= 1'b0;
            o_thr     <= '0;
            o_st      <= '0;
            o_elapsed <= '0;
            o_next    <= (op_r == CMD_EXPIRE) ? next_wait : '0;
            o_last    <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        S_OUT: begin
          // queue has settled after the pop: decide whether more follow
          if (more_due) begin
            state_r <= S_EXEC;
          end else begin
            o_last  <= 1'b1;
            o_next  <= next_wait;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/stq_checker.sv]
`timescale 1ns / 1ps
module stq_sva (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata,
  input logic         out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
  a_nowoke_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tlast)
    else $error("non-wake result not final");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad status");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted two items back to back");
endmodule

bind sorted_timer_wait_queue stq_sva u_sva (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tlast
);
